[hdl/lpiv_pkg.sv]
// Shared types and constants for the line pair intersection voter.
`default_nettype none
package lpiv_pkg;

    localparam int CMD_W    = 2;
    localparam int COL_IN_W = 10;
    localparam int ROW_IN_W = 9;
    localparam int VAL_W    = 8;
    localparam int WT_W     = 10;

    localparam logic [CMD_W-1:0] CMD_VOTE   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RD_PIX = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RD_ROW = 2'd2;

    localparam logic [VAL_W-1:0] SAT_MAX       = 8'd255;
    localparam logic [VAL_W-1:0] HORIZON_RESET = 8'd100;
    localparam logic [WT_W-1:0]  WEIGHT_MAX    = 10'd1023;

    // datapath widths
    localparam int OPA_W  = 12;  // line coefficients a, b
    localparam int OPB_W  = 23;  // endpoints, coefficients or c terms
    localparam int PROD_W = 35;
    localparam int C_W    = 23;
    localparam int DET_W  = 23;
    localparam int NUM_W  = 33;
    localparam int SQ_W   = 22;  // squared segment length
    localparam int RT_W   = SQ_W / 2;

    localparam int MUL_STEPS = 14;
    localparam int STEP_W    = 4;
    localparam int DIV_STEPS = NUM_W;
    localparam int CNT_W     = 6;

    typedef logic [STEP_W-1:0] step_t;

    typedef struct packed {
        logic  capture;
        logic  mul_en;
        step_t mul_step;
        logic  iter_start;
        logic  iter_step;
        logic  pt_load;
        logic  addr_load;
        logic  mem_rd;
        logic  mem_wr;
        logic  out_load;
        logic  clr_step;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic out_busy;
    } dp_stat_t;

endpackage
`default_nettype wire

[hdl/lpiv_div.sv]
// Restoring signed divider, one quotient bit per cycle while step is high, truncating toward zero.
`default_nettype none
module lpiv_div #(
    parameter int N_W = 33,
    parameter int D_W = 23
) (
    input  wire logic                  aclk,
    input  wire logic                  start,
    input  wire logic                  step,
    input  wire logic signed [N_W-1:0] num,
    input  wire logic signed [D_W-1:0] den,
    output logic signed [N_W-1:0]      quo
);

    logic [N_W-1:0] q_reg;
    logic [D_W-1:0] rem_reg;
    logic [D_W-1:0] d_reg;
    logic           neg_reg;
    logic [D_W:0]   shifted;
    logic [D_W:0]   diff;

    assign shifted = {rem_reg, q_reg[N_W-1]};
    assign diff    = shifted - {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg   <= num[N_W-1] ? N_W'(-num) : N_W'(num);
            d_reg   <= den[D_W-1] ? D_W'(-den) : D_W'(den);
            neg_reg <= num[N_W-1] ^ den[D_W-1];
            rem_reg <= '0;
        end else if (step) begin
            if (shifted >= {1'b0, d_reg}) begin
                rem_reg <= diff[D_W-1:0];
                q_reg   <= {q_reg[N_W-2:0], 1'b1};
            end else begin
                rem_reg <= shifted[D_W-1:0];
                q_reg   <= {q_reg[N_W-2:0], 1'b0};
            end
        end
    end

    assign quo = neg_reg ? -$signed(q_reg) : $signed(q_reg);

endmodule
`default_nettype wire

[hdl/lpiv_isqrt.sv]
// Bitwise integer floor square root, one result bit per cycle while step is high.
`default_nettype none
module lpiv_isqrt #(
    parameter int V_W = 22
) (
    input  wire logic           aclk,
    input  wire logic           start,
    input  wire logic           step,
    input  wire logic [V_W-1:0] val,
    output logic [V_W/2-1:0]    root
);

    logic [V_W-1:0] v_reg;
    logic [V_W-1:0] root_reg;
    logic [V_W-1:0] bit_reg;
    logic [V_W-1:0] trial;

    assign trial = root_reg + bit_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg    <= val;
            root_reg <= '0;
            bit_reg  <= V_W'(1) << (V_W - 2);
        end else if (step && (bit_reg != '0)) begin
            if (v_reg >= trial) begin
                v_reg    <= v_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end else begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign root = root_reg[V_W/2-1:0];

endmodule
`default_nettype wire

[hdl/lpiv_dp.sv]
// Datapath: input capture, shared multiplier, dividers, roots, vote stores, result register.
`default_nettype none
module lpiv_dp #(
    parameter int IMAGE_WIDTH  = 640,
    parameter int IMAGE_HEIGHT = 480
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire lpiv_pkg::dp_cmd_t     cmd,
    output lpiv_pkg::dp_stat_t         stat,
    input  wire logic                  cfg_wr_en,
    input  wire logic [7:0]            cfg_wr_data,
    input  wire logic [1:0]            s_command,
    input  wire logic [9:0]            s_a_x1,
    input  wire logic [8:0]            s_a_y1,
    input  wire logic [9:0]            s_a_x2,
    input  wire logic [8:0]            s_a_y2,
    input  wire logic [9:0]            s_b_x1,
    input  wire logic [8:0]            s_b_y1,
    input  wire logic [9:0]            s_b_x2,
    input  wire logic [8:0]            s_b_y2,
    input  wire logic [8:0]            s_row_offset,
    input  wire logic [9:0]            s_read_col,
    input  wire logic [8:0]            s_read_row,
    input  wire logic                  m_ready,
    output logic                       m_valid,
    output logic                       m_hit,
    output logic [9:0]                 m_cross_col,
    output logic [8:0]                 m_cross_row,
    output logic [9:0]                 m_weight,
    output logic [7:0]                 m_vote_value,
    output logic [7:0]                 m_row_score,
    output logic                       m_row_is_horizon
);

    localparam int COL_W  = $clog2(IMAGE_WIDTH);
    localparam int ROW_W  = $clog2(IMAGE_HEIGHT);
    localparam int PIX_N  = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int ADDR_W = $clog2(PIX_N);
    localparam int NUM_W  = lpiv_pkg::NUM_W;
    localparam int OPA_W  = lpiv_pkg::OPA_W;
    localparam int OPB_W  = lpiv_pkg::OPB_W;
    localparam int PROD_W = lpiv_pkg::PROD_W;
    localparam int C_W    = lpiv_pkg::C_W;
    localparam int DET_W  = lpiv_pkg::DET_W;
    localparam int SQ_W   = lpiv_pkg::SQ_W;
    localparam int RT_W   = lpiv_pkg::RT_W;
    localparam logic signed [NUM_W-1:0] W_S = NUM_W'(IMAGE_WIDTH);
    localparam logic signed [NUM_W-1:0] H_S = NUM_W'(IMAGE_HEIGHT);
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(PIX_N - 1);

    // multiplier schedule
    localparam lpiv_pkg::step_t ST_C1_LD  = 4'd0;
    localparam lpiv_pkg::step_t ST_C1_ADD = 4'd1;
    localparam lpiv_pkg::step_t ST_C2_LD  = 4'd2;
    localparam lpiv_pkg::step_t ST_C2_ADD = 4'd3;
    localparam lpiv_pkg::step_t ST_DET_LD = 4'd4;
    localparam lpiv_pkg::step_t ST_DET_SUB = 4'd5;
    localparam lpiv_pkg::step_t ST_XN_LD  = 4'd6;
    localparam lpiv_pkg::step_t ST_XN_SUB = 4'd7;
    localparam lpiv_pkg::step_t ST_YN_LD  = 4'd8;
    localparam lpiv_pkg::step_t ST_YN_SUB = 4'd9;
    localparam lpiv_pkg::step_t ST_LA_LD  = 4'd10;
    localparam lpiv_pkg::step_t ST_LA_ADD = 4'd11;
    localparam lpiv_pkg::step_t ST_LB_LD  = 4'd12;
    localparam lpiv_pkg::step_t ST_LB_ADD = 4'd13;

    // captured request
    logic [1:0] cmd_reg;
    logic [9:0] ax1_reg, ax2_reg, bx1_reg, bx2_reg, rcol_reg;
    logic [8:0] ay1_reg, ay2_reg, by1_reg, by2_reg, roff_reg, rrow_reg;

    logic signed [9:0]  a1, a2;
    logic signed [10:0] b1, b2;

    logic signed [OPA_W-1:0]  opa;
    logic signed [OPB_W-1:0]  opb;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     mul_d_reg;
    lpiv_pkg::step_t          step_d_reg;

    logic signed [C_W-1:0]   c1_reg, c2_reg;
    logic signed [DET_W-1:0] det_reg;
    logic signed [NUM_W-1:0] xn_reg, yn_reg;
    logic [SQ_W-1:0]         la_reg, lb_reg;

    logic signed [NUM_W-1:0] quo_x, quo_y, yq;
    logic [RT_W-1:0]         root_a, root_b, root_min;
    logic [9:0]              wt;

    logic             is_vote, is_read, rd_row_ok, rd_col_ok, inb;
    logic [NUM_W-1:0] rcol_wide, rrow_wide;

    logic [COL_W-1:0]  pt_x_reg;
    logic [ROW_W-1:0]  pt_y_reg;
    logic              hit_reg, do_pix_reg, do_row_reg;
    logic [9:0]        wt_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [7:0]        pix_q_reg, row_q_reg;

    logic [10:0]      pix_sum, row_sum;
    logic [7:0]       new_pix, new_row, rs_sel;
    logic [NUM_W-1:0] ptx_wide, pty_wide;

    logic       res_hit_reg, res_hor_reg;
    logic [9:0] res_col_reg, res_wt_reg;
    logic [8:0] res_row_reg;
    logic [7:0] res_vv_reg, res_rs_reg;

    logic       m_valid_reg, m_hit_reg, m_hor_reg;
    logic [9:0] m_cross_col_reg, m_weight_reg;
    logic [8:0] m_cross_row_reg;
    logic [7:0] m_vv_reg, m_rs_reg;

    logic [7:0]        thr_reg;
    logic [ADDR_W-1:0] clr_addr_reg;

    logic [7:0] pix_mem [PIX_N];
    logic [7:0] row_mem [IMAGE_HEIGHT];

    // line coefficients: a = y2 - y1, b = x1 - x2
    assign a1 = $signed({1'b0, ay2_reg}) - $signed({1'b0, ay1_reg});
    assign a2 = $signed({1'b0, by2_reg}) - $signed({1'b0, by1_reg});
    assign b1 = $signed({1'b0, ax1_reg}) - $signed({1'b0, ax2_reg});
    assign b2 = $signed({1'b0, bx1_reg}) - $signed({1'b0, bx2_reg});

    always_comb begin
        opa = OPA_W'(a1);
        opb = OPB_W'(a1);
        case (cmd.mul_step)
            ST_C1_LD:   begin opa = OPA_W'(a1); opb = OPB_W'($signed({1'b0, ax1_reg})); end
            ST_C1_ADD:  begin opa = OPA_W'(b1); opb = OPB_W'($signed({1'b0, ay1_reg})); end
            ST_C2_LD:   begin opa = OPA_W'(a2); opb = OPB_W'($signed({1'b0, bx1_reg})); end
            ST_C2_ADD:  begin opa = OPA_W'(b2); opb = OPB_W'($signed({1'b0, by1_reg})); end
            ST_DET_LD:  begin opa = OPA_W'(a1); opb = OPB_W'(b2); end
            ST_DET_SUB: begin opa = OPA_W'(a2); opb = OPB_W'(b1); end
            ST_XN_LD:   begin opa = OPA_W'(b2); opb = OPB_W'(c1_reg); end
            ST_XN_SUB:  begin opa = OPA_W'(b1); opb = OPB_W'(c2_reg); end
            ST_YN_LD:   begin opa = OPA_W'(a1); opb = OPB_W'(c2_reg); end
            ST_YN_SUB:  begin opa = OPA_W'(a2); opb = OPB_W'(c1_reg); end
            ST_LA_LD:   begin opa = OPA_W'(a1); opb = OPB_W'(a1); end
            ST_LA_ADD:  begin opa = OPA_W'(b1); opb = OPB_W'(b1); end
            ST_LB_LD:   begin opa = OPA_W'(a2); opb = OPB_W'(a2); end
            ST_LB_ADD:  begin opa = OPA_W'(b2); opb = OPB_W'(b2); end
            default:    begin opa = OPA_W'(a1); opb = OPB_W'(a1); end
        endcase
    end

    lpiv_div #(.N_W(NUM_W), .D_W(DET_W)) u_div_x (
        .aclk(aclk), .start(cmd.iter_start), .step(cmd.iter_step),
        .num(xn_reg), .den(det_reg), .quo(quo_x)
    );
    lpiv_div #(.N_W(NUM_W), .D_W(DET_W)) u_div_y (
        .aclk(aclk), .start(cmd.iter_start), .step(cmd.iter_step),
        .num(yn_reg), .den(det_reg), .quo(quo_y)
    );
    lpiv_isqrt #(.V_W(SQ_W)) u_sqrt_a (
        .aclk(aclk), .start(cmd.iter_start), .step(cmd.iter_step),
        .val(la_reg), .root(root_a)
    );
    lpiv_isqrt #(.V_W(SQ_W)) u_sqrt_b (
        .aclk(aclk), .start(cmd.iter_start), .step(cmd.iter_step),
        .val(lb_reg), .root(root_b)
    );

    assign root_min = (root_a < root_b) ? root_a : root_b;
    assign wt = (root_min > RT_W'(lpiv_pkg::WEIGHT_MAX)) ? lpiv_pkg::WEIGHT_MAX
                                                         : root_min[9:0];

    assign is_vote   = (cmd_reg == lpiv_pkg::CMD_VOTE);
    assign is_read   = (cmd_reg == lpiv_pkg::CMD_RD_PIX) || (cmd_reg == lpiv_pkg::CMD_RD_ROW);
    assign rcol_wide = NUM_W'(rcol_reg);
    assign rrow_wide = NUM_W'(rrow_reg);
    assign rd_row_ok = (rrow_wide < NUM_W'(IMAGE_HEIGHT));
    assign rd_col_ok = (rcol_wide < NUM_W'(IMAGE_WIDTH));
    assign yq        = quo_y + $signed(NUM_W'(roff_reg));
    assign inb = (det_reg != '0) && (quo_x >= 0) && (quo_x < W_S) && (yq >= 0) && (yq < H_S);

    // saturating updates of both stores
    assign pix_sum = 11'(pix_q_reg) + 11'(wt_reg);
    assign row_sum = 11'(row_q_reg) + 11'(wt_reg >> 2);
    assign new_pix = (pix_sum > 11'(lpiv_pkg::SAT_MAX)) ? lpiv_pkg::SAT_MAX : pix_sum[7:0];
    assign new_row = (row_sum > 11'(lpiv_pkg::SAT_MAX)) ? lpiv_pkg::SAT_MAX : row_sum[7:0];
    assign rs_sel  = hit_reg ? new_row : (do_row_reg ? row_q_reg : 8'd0);
    assign ptx_wide = NUM_W'(pt_x_reg);
    assign pty_wide = NUM_W'(pt_y_reg);

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_d_reg    <= 1'b0;
            m_valid_reg  <= 1'b0;
            thr_reg      <= lpiv_pkg::HORIZON_RESET;
            clr_addr_reg <= '0;
        end else begin
            mul_d_reg <= cmd.mul_en;
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
            if (cmd.clr_step) begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg  <= s_command;
            ax1_reg  <= s_a_x1;  ay1_reg <= s_a_y1;
            ax2_reg  <= s_a_x2;  ay2_reg <= s_a_y2;
            bx1_reg  <= s_b_x1;  by1_reg <= s_b_y1;
            bx2_reg  <= s_b_x2;  by2_reg <= s_b_y2;
            roff_reg <= s_row_offset;
            rcol_reg <= s_read_col;
            rrow_reg <= s_read_row;
        end
        prod_reg   <= opa * opb;
        step_d_reg <= cmd.mul_step;
        if (mul_d_reg) begin
            case (step_d_reg)
                ST_C1_LD:   c1_reg  <= C_W'(prod_reg);
                ST_C1_ADD:  c1_reg  <= C_W'(c1_reg + prod_reg);
                ST_C2_LD:   c2_reg  <= C_W'(prod_reg);
                ST_C2_ADD:  c2_reg  <= C_W'(c2_reg + prod_reg);
                ST_DET_LD:  det_reg <= DET_W'(prod_reg);
                ST_DET_SUB: det_reg <= DET_W'(det_reg - prod_reg);
                ST_XN_LD:   xn_reg  <= NUM_W'(prod_reg);
                ST_XN_SUB:  xn_reg  <= NUM_W'(xn_reg - prod_reg);
                ST_YN_LD:   yn_reg  <= NUM_W'(prod_reg);
                ST_YN_SUB:  yn_reg  <= NUM_W'(yn_reg - prod_reg);
                ST_LA_LD:   la_reg  <= prod_reg[SQ_W-1:0];
                ST_LA_ADD:  la_reg  <= la_reg + prod_reg[SQ_W-1:0];
                ST_LB_LD:   lb_reg  <= prod_reg[SQ_W-1:0];
                ST_LB_ADD:  lb_reg  <= lb_reg + prod_reg[SQ_W-1:0];
                default:    c1_reg  <= c1_reg;
            endcase
        end
        if (cmd.pt_load) begin
            wt_reg <= is_vote ? wt : 10'd0;
            if (is_vote) begin
                pt_x_reg   <= quo_x[COL_W-1:0];
                pt_y_reg   <= yq[ROW_W-1:0];
                hit_reg    <= inb;
                do_pix_reg <= inb;
                do_row_reg <= inb;
            end else begin
                pt_x_reg   <= rcol_wide[COL_W-1:0];
                pt_y_reg   <= rrow_wide[ROW_W-1:0];
                hit_reg    <= 1'b0;
                do_row_reg <= is_read && rd_row_ok;
                do_pix_reg <= (cmd_reg == lpiv_pkg::CMD_RD_PIX) && rd_row_ok && rd_col_ok;
            end
        end
        if (cmd.addr_load) begin
            addr_reg <= ADDR_W'(pt_y_reg) * ADDR_W'(IMAGE_WIDTH) + ADDR_W'(pt_x_reg);
        end
        if (cmd.mem_rd) begin
            pix_q_reg <= pix_mem[addr_reg];
            row_q_reg <= row_mem[pt_y_reg];
        end
        if (cmd.clr_step) begin
            pix_mem[clr_addr_reg] <= 8'd0;
            if (clr_addr_reg < ADDR_W'(IMAGE_HEIGHT)) begin
                row_mem[clr_addr_reg[ROW_W-1:0]] <= 8'd0;
            end
        end else if (cmd.mem_wr && hit_reg) begin
            pix_mem[addr_reg] <= new_pix;
            row_mem[pt_y_reg] <= new_row;
        end
        if (cmd.mem_wr) begin
            res_hit_reg <= hit_reg;
            res_col_reg <= hit_reg ? ptx_wide[9:0] : 10'd0;
            res_row_reg <= hit_reg ? pty_wide[8:0] : 9'd0;
            res_wt_reg  <= wt_reg;
            res_vv_reg  <= hit_reg ? new_pix : (do_pix_reg ? pix_q_reg : 8'd0);
            res_rs_reg  <= rs_sel;
            res_hor_reg <= (hit_reg || is_read) && (rs_sel >= thr_reg);
        end
        if (cmd.out_load) begin
            m_hit_reg       <= res_hit_reg;
            m_cross_col_reg <= res_col_reg;
            m_cross_row_reg <= res_row_reg;
            m_weight_reg    <= res_wt_reg;
            m_vv_reg        <= res_vv_reg;
            m_rs_reg        <= res_rs_reg;
            m_hor_reg       <= res_hor_reg;
        end
    end

    assign stat.clr_last = (clr_addr_reg == CLR_LAST);
    assign stat.out_busy = m_valid_reg && !m_ready;

    assign m_valid          = m_valid_reg;
    assign m_hit            = m_hit_reg;
    assign m_cross_col      = m_cross_col_reg;
    assign m_cross_row      = m_cross_row_reg;
    assign m_weight         = m_weight_reg;
    assign m_vote_value     = m_vv_reg;
    assign m_row_score      = m_rs_reg;
    assign m_row_is_horizon = m_hor_reg;

    a_sat_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mem_wr && hit_reg |=> res_vv_reg >= $past(pix_q_reg))
        else $error("pixel vote decreased on update");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !(m_valid_reg && !m_ready))
        else $error("result register overwritten while pending");
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_hit_reg |-> m_cross_col_reg == '0 && m_cross_row_reg == '0)
        else $error("intersection fields set without hit");

endmodule
`default_nettype wire

[hdl/lpiv_ctrl.sv]
// Controller state machine sequencing clear, multiply, divide, store access and output.
`default_nettype none
module lpiv_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic [1:0]         s_command,
    input  wire lpiv_pkg::dp_stat_t stat,
    output logic                    s_ready,
    output lpiv_pkg::dp_cmd_t       cmd
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_MUL   = 4'd2;
    localparam logic [3:0] S_DIVI  = 4'd3;
    localparam logic [3:0] S_DIV   = 4'd4;
    localparam logic [3:0] S_PT    = 4'd5;
    localparam logic [3:0] S_ADDR  = 4'd6;
    localparam logic [3:0] S_RD    = 4'd7;
    localparam logic [3:0] S_MOD   = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    localparam int CNT_W = lpiv_pkg::CNT_W;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_ready    = 1'b0;
        cmd        = '0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    cnt_next    = '0;
                    state_next  = (s_command == lpiv_pkg::CMD_VOTE) ? S_MUL : S_PT;
                end
            end
            S_MUL: begin
                // a final pass with no product issued drains the last accumulate
                if (cnt_reg < CNT_W'(lpiv_pkg::MUL_STEPS)) begin
                    cmd.mul_en   = 1'b1;
                    cmd.mul_step = cnt_reg[lpiv_pkg::STEP_W-1:0];
                    cnt_next     = cnt_reg + 1'b1;
                end else begin
                    state_next = S_DIVI;
                end
            end
            S_DIVI: begin
                cmd.iter_start = 1'b1;
                cnt_next       = '0;
                state_next     = S_DIV;
            end
            S_DIV: begin
                cmd.iter_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(lpiv_pkg::DIV_STEPS - 1)) begin
                    state_next = S_PT;
                end
            end
            S_PT: begin
                cmd.pt_load = 1'b1;
                state_next  = S_ADDR;
            end
            S_ADDR: begin
                cmd.addr_load = 1'b1;
                state_next    = S_RD;
            end
            S_RD: begin
                cmd.mem_rd = 1'b1;
                state_next = S_MOD;
            end
            S_MOD: begin
                cmd.mem_wr = 1'b1;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request accepted while one is in flight");

endmodule
`default_nettype wire

[hdl/line_pair_intersection_voter.sv]
// Top level of the line pair intersection voter.
`default_nettype none
// Intersects the infinite lines through two segments in exact integer math
// and votes into a per-pixel store and a per-row score store, or reads them
// back. After reset the block sweeps both stores to zero, one pixel per
// cycle, and accepts no request until the sweep ends; threshold writes are
// taken throughout. One request is worked at a time. A vote request passes
// through the shared multiplier (14 products plus one accumulate), the two
// 33-bit restoring dividers (the square roots run alongside), then point
// check, address, store read, read-modify-write and the output register
// load. Read requests go straight to the point check. A finished result sits
// in the output register, so a new request can be accepted while it waits; a
// result that finds the register still full waits in the last step until the
// old one is taken.
module line_pair_intersection_voter #(
    parameter int IMAGE_WIDTH  = 640,
    parameter int IMAGE_HEIGHT = 480
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    // horizon threshold
    input  wire logic       cfg_wr_en,
    input  wire logic [7:0] cfg_wr_data,
    // request channel
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_command,
    input  wire logic [9:0] s_a_x1,
    input  wire logic [8:0] s_a_y1,
    input  wire logic [9:0] s_a_x2,
    input  wire logic [8:0] s_a_y2,
    input  wire logic [9:0] s_b_x1,
    input  wire logic [8:0] s_b_y1,
    input  wire logic [9:0] s_b_x2,
    input  wire logic [8:0] s_b_y2,
    input  wire logic [8:0] s_row_offset,
    input  wire logic [9:0] s_read_col,
    input  wire logic [8:0] s_read_row,
    // result channel
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_hit,
    output logic [9:0]      m_cross_col,
    output logic [8:0]      m_cross_row,
    output logic [9:0]      m_weight,
    output logic [7:0]      m_vote_value,
    output logic [7:0]      m_row_score,
    output logic            m_row_is_horizon
);

    lpiv_pkg::dp_cmd_t  dp_cmd;
    lpiv_pkg::dp_stat_t dp_stat;

    // sequencing lives in the controller, all arithmetic and stores in the datapath
    lpiv_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_command (s_command),
        .stat      (dp_stat),
        .s_ready   (s_ready),
        .cmd       (dp_cmd)
    );

    lpiv_dp #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (dp_cmd),
        .stat             (dp_stat),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_command        (s_command),
        .s_a_x1           (s_a_x1),
        .s_a_y1           (s_a_y1),
        .s_a_x2           (s_a_x2),
        .s_a_y2           (s_a_y2),
        .s_b_x1           (s_b_x1),
        .s_b_y1           (s_b_y1),
        .s_b_x2           (s_b_x2),
        .s_b_y2           (s_b_y2),
        .s_row_offset     (s_row_offset),
        .s_read_col       (s_read_col),
        .s_read_row       (s_read_row),
        .m_ready          (m_ready),
        .m_valid          (m_valid),
        .m_hit            (m_hit),
        .m_cross_col      (m_cross_col),
        .m_cross_row      (m_cross_row),
        .m_weight         (m_weight),
        .m_vote_value     (m_vote_value),
        .m_row_score      (m_row_score),
        .m_row_is_horizon (m_row_is_horizon)
    );

endmodule
`default_nettype wire
